FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/csrs_pkg.sv
// Package with types, constants and classification functions of the run score block.
`default_nettype none
package csrs_pkg;

    localparam int NUM_BUCKETS = 4;
    localparam int MAX_LENGTH = 65536;
    localparam int FIELD_MAX = 131071;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [16:0] SCORE_CAP =
        17'((MAX_LENGTH < FIELD_MAX) ? MAX_LENGTH : FIELD_MAX);

    localparam logic [7:0] UPPER_LO = 8'd65;
    localparam logic [7:0] UPPER_HI = 8'd90;
    localparam logic [7:0] CASE_STEP = 8'd32;

    // Configuration register indexes.
    localparam logic [7:0] REG_SYM_FIRST = 8'd0;
    localparam logic [7:0] REG_SYM_SECOND = 8'd1;
    localparam logic [7:0] REG_SYM_THIRD = 8'd2;
    localparam logic [7:0] REG_SYM_FOURTH = 8'd3;

    typedef logic [NUM_BUCKETS-1:0][7:0] t_sym_arr;

    localparam t_sym_arr RESET_SYMS = {8'd116, 8'd103, 8'd99, 8'd97};

    typedef struct packed {
        logic [7:0] head;
        logic [7:0] tail;
    } t_pair;

    typedef struct packed {
        logic       hit;
        logic [1:0] idx;
    } t_match;

    // One queued job: an optional append, and on the last byte the
    // opening pair that goes to the front of its bucket.
    typedef struct packed {
        logic       app_vld;
        logic [1:0] app_bkt;
        logic [7:0] app_tail;
        logic       fin;
        logic       pre_vld;
        logic [1:0] pre_bkt;
        logic [7:0] pre_tail;
    } t_op;

    typedef struct packed {
        logic busy;
    } t_back_stat;

    function automatic t_pair fold_pair(input logic [7:0] cur, input logic [7:0] prev);
        t_pair p;
        p.head = cur;
        p.tail = prev;
        if (cur >= UPPER_LO && cur <= UPPER_HI) begin
            p.head = cur + CASE_STEP;
            p.tail = prev + CASE_STEP;
        end
        return p;
    endfunction

    function automatic t_match find_bucket(input logic [7:0] head, input t_sym_arr syms);
        t_match m;
        m.hit = 1'b0;
        m.idx = 2'd0;
        for (int k = NUM_BUCKETS - 1; k >= 0; k--) begin
            if (syms[k] == head) begin
                m.hit = 1'b1;
                m.idx = 2'(k);
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: sv/csrs_front.sv
// Front part: configuration registers, sequence tracking and pair classification.
`default_nettype none
module csrs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [7:0]    i_symbol,
    input  wire logic          i_final_req,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [7:0]    i_cfg_index,
    input  wire logic [7:0]    i_cfg_data,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output csrs_pkg::t_op      o_q_op
);
    import csrs_pkg::*;

    t_sym_arr   r_syms;
    logic [7:0] r_opening;
    logic [7:0] r_prior;
    logic       r_seen;

    logic       accept;
    logic [7:0] opening_eff;
    t_pair      app_pair;
    t_pair      pre_pair;
    t_match     app_m;
    t_match     pre_m;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    assign opening_eff = r_seen ? r_opening : i_symbol;
    assign app_pair    = fold_pair(i_symbol, r_prior);
    assign pre_pair    = fold_pair(opening_eff, i_symbol);
    assign app_m       = find_bucket(app_pair.head, r_syms);
    assign pre_m       = find_bucket(pre_pair.head, r_syms);

    always_comb begin
        o_q_op.app_vld  = r_seen && app_m.hit;
        o_q_op.app_bkt  = app_m.idx;
        o_q_op.app_tail = app_pair.tail;
        o_q_op.fin      = i_final_req;
        o_q_op.pre_vld  = pre_m.hit;
        o_q_op.pre_bkt  = pre_m.idx;
        o_q_op.pre_tail = pre_pair.tail;
    end

    // Items that touch no bucket and do not end the sequence are not queued.
    assign o_q_push = accept && (o_q_op.app_vld || i_final_req);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_syms    <= RESET_SYMS;
            r_opening <= 8'd0;
            r_prior   <= 8'd0;
            r_seen    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SYM_FIRST:  r_syms[0] <= i_cfg_data;
                    REG_SYM_SECOND: r_syms[1] <= i_cfg_data;
                    REG_SYM_THIRD:  r_syms[2] <= i_cfg_data;
                    REG_SYM_FOURTH: r_syms[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                if (i_final_req) begin
                    r_seen    <= 1'b0;
                    r_opening <= 8'd0;
                    r_prior   <= 8'd0;
                end else begin
                    r_seen  <= 1'b1;
                    r_prior <= i_symbol;
                    if (!r_seen) begin
                        r_opening <= i_symbol;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/csrs_queue.sv
// Short register queue that decouples the front part from the back part.
`default_nettype none
module csrs_queue #(
    parameter int DEPTH = csrs_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire csrs_pkg::t_op i_op,
    input  wire logic          i_pop,
    output csrs_pkg::t_op      o_op,
    output logic               o_full,
    output logic               o_empty
);
    import csrs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_op           r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/csrs_back.sv
// Back part: per-bucket run state, score accumulation and the result register.
`default_nettype none
module csrs_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire csrs_pkg::t_op   i_q_op,
    input  wire logic            i_q_empty,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [16:0]          o_score,
    output csrs_pkg::t_back_stat o_stat
);
    import csrs_pkg::*;

    localparam logic [1:0] PH_RUN = 2'd0;
    localparam logic [1:0] PH_PRE = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;
    localparam logic [1:0] PH_OUT = 2'd3;

    logic [1:0]  r_ph, n_ph;
    logic [1:0]  r_k, n_k;
    logic [16:0] r_acc, n_acc;
    logic        r_have, n_have;
    logic [7:0]  r_last, n_last;
    logic        r_used [NUM_BUCKETS];
    logic [7:0]  r_head [NUM_BUCKETS];
    logic [7:0]  r_end  [NUM_BUCKETS];
    logic [16:0] r_chg  [NUM_BUCKETS];
    logic        n_used [NUM_BUCKETS];
    logic [7:0]  n_head [NUM_BUCKETS];
    logic [7:0]  n_end  [NUM_BUCKETS];
    logic [16:0] n_chg  [NUM_BUCKETS];
    logic        r_out_valid;
    logic [16:0] r_score;

    logic        out_free;
    logic        load_out;
    logic [18:0] sum;
    logic        step_inc;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;
    assign o_stat.busy = (r_ph != PH_RUN);

    assign step_inc = r_have && (r_last != r_head[r_k]);
    assign sum = {2'b00, r_acc} + {2'b00, r_chg[r_k]} + 19'(step_inc);

    function automatic logic [16:0] sat_inc(input logic [16:0] v);
        return (v >= SCORE_CAP) ? SCORE_CAP : v + 17'd1;
    endfunction

    always_comb begin
        n_ph     = r_ph;
        n_k      = r_k;
        n_acc    = r_acc;
        n_have   = r_have;
        n_last   = r_last;
        n_used   = r_used;
        n_head   = r_head;
        n_end    = r_end;
        n_chg    = r_chg;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_ph)
            PH_RUN: begin
                if (!i_q_empty) begin
                    if (i_q_op.app_vld) begin
                        if (!r_used[i_q_op.app_bkt]) begin
                            n_used[i_q_op.app_bkt] = 1'b1;
                            n_head[i_q_op.app_bkt] = i_q_op.app_tail;
                            n_end[i_q_op.app_bkt]  = i_q_op.app_tail;
                            n_chg[i_q_op.app_bkt]  = 17'd0;
                        end else begin
                            if (i_q_op.app_tail != r_end[i_q_op.app_bkt]) begin
                                n_chg[i_q_op.app_bkt] = sat_inc(r_chg[i_q_op.app_bkt]);
                            end
                            n_end[i_q_op.app_bkt] = i_q_op.app_tail;
                        end
                    end
                    if (i_q_op.fin) begin
                        n_ph = PH_PRE;
                    end else begin
                        o_q_pop = 1'b1;
                    end
                end
            end
            PH_PRE: begin
                if (i_q_op.pre_vld) begin
                    if (!r_used[i_q_op.pre_bkt]) begin
                        n_used[i_q_op.pre_bkt] = 1'b1;
                        n_head[i_q_op.pre_bkt] = i_q_op.pre_tail;
                        n_end[i_q_op.pre_bkt]  = i_q_op.pre_tail;
                        n_chg[i_q_op.pre_bkt]  = 17'd0;
                    end else begin
                        if (i_q_op.pre_tail != r_head[i_q_op.pre_bkt]) begin
                            n_chg[i_q_op.pre_bkt] = sat_inc(r_chg[i_q_op.pre_bkt]);
                        end
                        n_head[i_q_op.pre_bkt] = i_q_op.pre_tail;
                    end
                end
                n_ph   = PH_SUM;
                n_k    = 2'd0;
                n_acc  = 17'd1;
                n_have = 1'b0;
                n_last = 8'd0;
            end
            PH_SUM: begin
                if (r_used[r_k]) begin
                    n_acc  = (sum >= {2'b00, SCORE_CAP}) ? SCORE_CAP : sum[16:0];
                    n_last = r_end[r_k];
                    n_have = 1'b1;
                end
                n_k = r_k + 2'd1;
                if (r_k == 2'(NUM_BUCKETS - 1)) begin
                    n_ph = PH_OUT;
                end
            end
            PH_OUT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    o_q_pop  = 1'b1;
                    n_ph     = PH_RUN;
                    for (int b = 0; b < NUM_BUCKETS; b++) begin
                        n_used[b] = 1'b0;
                        n_head[b] = 8'd0;
                        n_end[b]  = 8'd0;
                        n_chg[b]  = 17'd0;
                    end
                end
            end
            default: n_ph = PH_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_RUN;
            r_k         <= 2'd0;
            r_acc       <= 17'd1;
            r_have      <= 1'b0;
            r_last      <= 8'd0;
            r_out_valid <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_used[b] <= 1'b0;
                r_head[b] <= 8'd0;
                r_end[b]  <= 8'd0;
                r_chg[b]  <= 17'd0;
            end
        end else begin
            r_ph   <= n_ph;
            r_k    <= n_k;
            r_acc  <= n_acc;
            r_have <= n_have;
            r_last <= n_last;
            r_used <= n_used;
            r_head <= n_head;
            r_end  <= n_end;
            r_chg  <= n_chg;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_score <= r_acc;
        end
    end

endmodule
`default_nettype wire

FILE: sv/context_sorted_run_score.sv
// Top level of the context sorted run score block: front, queue and back.
//
//  Channel  | Direction | Handshake                 | Payload
//  ---------+-----------+---------------------------+------------------------------
//  input    | in        | i_in_valid / o_in_ready   | i_symbol[7:0], i_final_req
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index[7:0], i_cfg_data[7:0]
//  result   | out       | o_out_valid / i_out_ready | o_score[16:0]
//
// Input is taken each cycle the queue has room; a queued byte (a bucket hit or a last byte)
// is handled by the back part in its run state, but a last byte holds it through the append,
// opening-pair merge, four bucket sums and load. The queue takes three more jobs meanwhile;
// then the input stalls until that job is popped. Reset is synchronous and active low; it
// restores the symbol registers and clears all sequence state. A stalled result holds the
// back part at its load step only, so the front keeps accepting until the queue fills.
`default_nettype none
`include "assert_macros.svh"
module context_sorted_run_score #(
    parameter int QUEUE_DEPTH = csrs_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_final_req,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [16:0]      o_score
);
    import csrs_pkg::*;

    // Jobs from the front part travel through the queue to the back part.
    t_op        push_op;
    t_op        head_op;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    t_back_stat back_stat;

    // The front classifies each byte against the symbol registers as it arrives, which
    // matches bucketing with the registers current when the pair is formed.
    csrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_symbol    (i_symbol),
        .i_final_req (i_final_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_op      (push_op)
    );

    csrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .i_pop   (q_pop),
        .o_op    (head_op),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back part keeps the job of a last byte at the queue head until the score has
    // been loaded into the result register, then pops it and clears the buckets.
    csrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_op      (head_op),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_score     (o_score),
        .o_stat      (back_stat)
    );

    // The front never pushes into a full queue.
    `ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, q_push, !q_full)
    // While the back part works on a last byte, its job stays at the queue head.
    `ASSERT_SAME(a_busy_has_job, i_clk, i_rst_n, back_stat.busy, !q_empty)
    // A delivered score lies between one and the saturation cap.
    `ASSERT_SAME(a_score_range, i_clk, i_rst_n, o_out_valid,
        (o_score != 17'd0) && (o_score <= SCORE_CAP))
    // A pop from an empty queue would lose track of the job order.
    `ASSERT_NEXT(a_pop_nonempty, i_clk, i_rst_n, q_pop && !q_push && q_empty, 1'b0)

endmodule
`default_nettype wire
